FILE: src/mdu_pkg.sv
// mdu_pkg: shared types and constants of the multiply-divide unit
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package mdu_pkg;
    localparam int unsigned W = 64;
    localparam logic [W-1:0] ALL_ONES = '1;
    localparam logic ACT_UNSIGNED = 1'b0;
    localparam logic ACT_SIGNED = 1'b1;

    typedef struct packed {
        logic         action;
        logic         neg;
        logic [W-1:0] ma;
        logic [W-1:0] mb;
        logic [W-1:0] mc;
    } t_job;
endpackage
`default_nettype wire

FILE: src/mdu_front.sv
// mdu_front: input register, operand classification into magnitudes and sign
// depends on mdu_pkg
`timescale 1ns / 1ps
`default_nettype none
module mdu_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic         i_action,
    input  wire logic [63:0]  i_a,
    input  wire logic [63:0]  i_b,
    input  wire logic [63:0]  i_c,
    output logic              o_valid,
    input  wire logic         i_ready,
    output mdu_pkg::t_job     o_job
);
    logic          r_valid;
    mdu_pkg::t_job r_job;
    mdu_pkg::t_job n_job;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_job   = r_job;

    always_comb begin
        n_job.action = i_action;
        if (i_action == mdu_pkg::ACT_SIGNED) begin
            n_job.ma  = i_a[63] ? (~i_a + 64'd1) : i_a;
            n_job.mb  = i_b[63] ? (~i_b + 64'd1) : i_b;
            n_job.mc  = i_c[63] ? (~i_c + 64'd1) : i_c;
            n_job.neg = i_a[63] ^ i_b[63] ^ i_c[63];
        end else begin
            n_job.ma  = i_a;
            n_job.mb  = {32'd0, i_b[31:0]};
            n_job.mc  = {32'd0, i_c[31:0]};
            n_job.neg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end
endmodule
`default_nettype wire

FILE: src/mdu_fifo.sv
// mdu_fifo: short job queue between front and back
// depends on mdu_pkg
`timescale 1ns / 1ps
`default_nettype none
module mdu_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  mdu_pkg::t_job      i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output mdu_pkg::t_job      o_job
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULLC = CW'(DEPTH);

    mdu_pkg::t_job r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == FULLC);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PW'(1);
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULLC) else $error("queue count beyond depth");
endmodule
`default_nettype wire

FILE: src/mdu_back.sv
// mdu_back: pipelined 64x64 multiply, 64-stage restoring divide, rounding and sign
// depends on mdu_pkg
`timescale 1ns / 1ps
`default_nettype none
module mdu_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  mdu_pkg::t_job     i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [63:0]       o_quotient,
    output logic [31:0]       o_remainder,
    output logic              o_overflow
);
    localparam int unsigned NS = 64;

    typedef struct packed {
        logic        action;
        logic        neg;
        logic        ovf;
        logic [63:0] d;
        logic [63:0] r;
        logic [63:0] w;
    } t_dstg;

    logic en;

    // multiply stage 1: partial products
    logic          r_m1_v;
    logic [63:0]   r_p00, r_p01, r_p10, r_p11;
    logic [63:0]   r_m1_c;
    logic          r_m1_act, r_m1_neg;
    // multiply stage 2: full product
    logic          r_m2_v;
    logic [127:0]  r_m2_p;
    logic [63:0]   r_m2_c;
    logic          r_m2_act, r_m2_neg;

    logic          r_dv [0:NS];
    t_dstg         r_ds [0:NS];

    logic          r_out_v;
    logic          r_out_act;
    logic [63:0]   r_out_q;
    logic [31:0]   r_out_rem;
    logic          r_out_ovf;

    assign en      = !r_out_v || i_ready;
    assign o_pop   = en && i_valid;
    assign o_valid = r_out_v;
    assign o_quotient  = r_out_q;
    assign o_remainder = r_out_rem;
    assign o_overflow  = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_dv[0] <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_m1_v <= i_valid;
            r_m2_v <= r_m1_v;
            r_dv[0] <= r_m2_v;
            r_out_v <= r_dv[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p00 <= i_job.ma[31:0]  * i_job.mb[31:0];
            r_p01 <= i_job.ma[31:0]  * i_job.mb[63:32];
            r_p10 <= i_job.ma[63:32] * i_job.mb[31:0];
            r_p11 <= i_job.ma[63:32] * i_job.mb[63:32];
            r_m1_c   <= i_job.mc;
            r_m1_act <= i_job.action;
            r_m1_neg <= i_job.neg;

            r_m2_p <= {r_p11, r_p00} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0};
            r_m2_c   <= r_m1_c;
            r_m2_act <= r_m1_act;
            r_m2_neg <= r_m1_neg;

            r_ds[0].action <= r_m2_act;
            r_ds[0].neg    <= r_m2_neg;
            r_ds[0].ovf    <= (r_m2_p[127:64] >= r_m2_c);
            r_ds[0].d      <= r_m2_c;
            r_ds[0].r      <= r_m2_p[127:64];
            r_ds[0].w      <= r_m2_p[63:0];
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < NS; k++) begin : g_div
        logic [64:0] sh;
        logic        ge;
        assign sh = {r_ds[k].r, r_ds[k].w[63]};
        assign ge = sh[64] || (sh[63:0] >= r_ds[k].d);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ds[k+1].action <= r_ds[k].action;
                r_ds[k+1].neg    <= r_ds[k].neg;
                r_ds[k+1].ovf    <= r_ds[k].ovf;
                r_ds[k+1].d      <= r_ds[k].d;
                r_ds[k+1].r      <= ge ? (sh[63:0] - r_ds[k].d) : sh[63:0];
                r_ds[k+1].w      <= {r_ds[k].w[62:0], ge};
            end
        end
    end

    logic        rnd;
    logic        ovf_f;
    logic [63:0] q2;
    logic [63:0] qs;

    always_comb begin
        rnd   = (r_ds[NS].action == mdu_pkg::ACT_SIGNED)
                && (r_ds[NS].r >= (r_ds[NS].d - r_ds[NS].r));
        ovf_f = r_ds[NS].ovf || (rnd && (r_ds[NS].w == mdu_pkg::ALL_ONES));
        q2    = r_ds[NS].w + 64'(rnd);
        qs    = r_ds[NS].neg ? (~q2 + 64'd1) : q2;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_act <= r_ds[NS].action;
            r_out_ovf <= ovf_f;
            r_out_q   <= ovf_f ? mdu_pkg::ALL_ONES : qs;
            if (ovf_f || r_ds[NS].action == mdu_pkg::ACT_SIGNED) begin
                r_out_rem <= 32'd0;
            end else begin
                r_out_rem <= r_ds[NS].r[31:0];
            end
        end
    end

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_ovf |-> r_out_q == mdu_pkg::ALL_ONES && r_out_rem == 32'd0)
        else $error("overflow result not saturated");
    a_signed_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_act == mdu_pkg::ACT_SIGNED |-> r_out_rem == 32'd0)
        else $error("signed result carries a remainder");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_dv[NS]) && $stable(r_m1_v))
        else $error("pipeline moved while stalled");
endmodule
`default_nettype wire

FILE: src/mul_div_64_unit.sv
// mul_div_64_unit: top level of the 64-bit multiply-then-divide unit
// depends on mdu_pkg, mdu_front, mdu_fifo, mdu_back
//
// usage: one request beat on s_axis gives one result beat on m_axis, in order.
// action 0 (tuser=0): unsigned a * b[31:0] / c[31:0], quotient and remainder.
// action 1 (tuser=1): signed a * b / c on magnitudes, rounded half up, signed.
// overflow or zero divisor: quotient all ones, remainder zero, m_axis_tuser=1.
// path: input register, queue, two multiply stages, overflow check,
// 64 divide stages and output register, from request beat to result valid.
// throughput: one beat per cycle while m_axis is not stalled; every divide stage
// resolves one quotient bit and the multiplier is split into four registered
// 32x32 products. a stalled receiver freezes the back pipeline; the front keeps
// taking beats until queue and input register are full, then s_axis_tready drops.
// reset clears all valid flags; no results are pending after reset.
`timescale 1ns / 1ps
`default_nettype none
module mul_div_64_unit #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [191:0]  s_axis_tdata,  // multiplicand, multiplier, divisor
    input  wire logic          s_axis_tuser,  // action
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [95:0]        m_axis_tdata,  // quotient, remainder_out
    output logic               m_axis_tuser   // overflow
);
    logic          f_valid;
    logic          q_full;
    logic          q_valid;
    logic          b_pop;
    mdu_pkg::t_job f_job;
    mdu_pkg::t_job q_job;

    mdu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_action (s_axis_tuser),
        .i_a      (s_axis_tdata[63:0]),
        .i_b      (s_axis_tdata[127:64]),
        .i_c      (s_axis_tdata[191:128]),
        .o_valid  (f_valid),
        .i_ready  (!q_full),
        .o_job    (f_job)
    );

    mdu_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    mdu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_job       (q_job),
        .o_pop       (b_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_quotient  (m_axis_tdata[63:0]),
        .o_remainder (m_axis_tdata[95:64]),
        .o_overflow  (m_axis_tuser)
    );
endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// testbench: self-checking bench for mul_div_64_unit, streaming beats in and out
// drives directed and random scale requests, predicts each result in place
`timescale 1ns / 1ps
`default_nettype none
module testbench;

    localparam int unsigned N_RANDOM = 1700;
    localparam longint unsigned CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic         action;
        logic [63:0]  a;
        logic [63:0]  b;
        logic [63:0]  c;
    } t_req;

    typedef struct packed {
        logic [63:0] quotient;
        logic [31:0] rem;
        logic        ovf;
    } t_scaled;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [191:0]  s_axis_tdata;   // multiplicand, multiplier, divisor
    logic          s_axis_tuser;   // action
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [95:0]   m_axis_tdata;   // quotient, remainder_out
    logic          m_axis_tuser;   // overflow

    t_req          pending_reqs[$];
    t_scaled       expected_results[$];
    int            n_errors = 0;
    int            n_results = 0;
    int            n_overflows = 0;
    int            n_signed = 0;
    longint unsigned cycle_count = 0;
    bit            stim_done = 0;
    bit            hold_sender = 0;
    bit            in_taken = 0;
    int            send_gap = 0;
    int            recv_gap = 0;

    mul_div_64_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] abs64(input logic [63:0] v, inout logic neg);
        if (v[63]) begin
            neg = ~neg;
            return -v;
        end
        return v;
    endfunction

    function automatic t_scaled scale_request(input t_req rq);
        t_scaled      res;
        logic [127:0] prod;
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [63:0]  mc;
        logic [63:0]  q;
        logic [63:0]  r;
        logic         neg;
        res = '{quotient: mdu_pkg::ALL_ONES, rem: '0, ovf: 1'b1};
        neg = 1'b0;
        if (rq.action == mdu_pkg::ACT_UNSIGNED) begin
            mc = {32'd0, rq.c[31:0]};
            prod = {64'd0, rq.a} * {96'd0, rq.b[31:0]};
            if (prod[127:64] >= mc) return res;
            q = 64'(prod / {64'd0, mc});
            r = 64'(prod % {64'd0, mc});
            res = '{quotient: q, rem: r[31:0], ovf: 1'b0};
        end else begin
            ma = abs64(rq.a, neg);
            mb = abs64(rq.b, neg);
            mc = abs64(rq.c, neg);
            prod = {64'd0, ma} * {64'd0, mb};
            if (prod[127:64] >= mc) return res;
            q = 64'(prod / {64'd0, mc});
            r = 64'(prod % {64'd0, mc});
            // exact half-up compare on the remainder
            if ({1'b0, r, 1'b0} >= {1'b0, 1'b0, mc}) begin
                if (q == mdu_pkg::ALL_ONES) return res;
                q = q + 64'd1;
            end
            res = '{quotient: neg ? -q : q, rem: '0, ovf: 1'b0};
        end
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = v >> $urandom_range(0, 63);
            1: v = ~(v >> $urandom_range(0, 63));
            2: v = {64{v[0]}} ^ {63'd0, v[1]};
            default: ;
        endcase
        return v;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 2) != 0) return 0;
        if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_taken) begin
        end else if (send_gap > 0 || hold_sender || pending_reqs.size() == 0) begin
            if (send_gap > 0) send_gap <= send_gap - 1;
            s_axis_tvalid <= 1'b0;
        end else begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {pending_reqs[0].c, pending_reqs[0].b, pending_reqs[0].a};
            s_axis_tuser  <= pending_reqs[0].action;
            expected_results.push_back(scale_request(pending_reqs[0]));
            if (pending_reqs[0].action == mdu_pkg::ACT_SIGNED) n_signed++;
            void'(pending_reqs.pop_front());
            send_gap <= ($urandom_range(0, 7) == 0) ? 0 : pick_gap();
        end
        if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_scaled exp_res;
        cycle_count <= cycle_count + 1;
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results <= n_results + 1;
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected: %h", m_axis_tdata);
                n_errors++;
            end else begin
                exp_res = expected_results.pop_front();
                if (exp_res.ovf) n_overflows <= n_overflows + 1;
                if (m_axis_tdata[63:0] !== exp_res.quotient) begin
                    $error("quotient exp %h got %h", exp_res.quotient, m_axis_tdata[63:0]);
                    n_errors++;
                end
                if (m_axis_tdata[95:64] !== exp_res.rem) begin
                    $error("remainder_out exp %h got %h", exp_res.rem, m_axis_tdata[95:64]);
                    n_errors++;
                end
                if (m_axis_tuser !== exp_res.ovf) begin
                    $error("overflow exp %b got %b", exp_res.ovf, m_axis_tuser);
                    n_errors++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic add_req(input logic act, input logic [63:0] a,
                           input logic [63:0] b, input logic [63:0] c);
        pending_reqs.push_back('{action: act, a: a, b: b, c: c});
    endtask

    initial begin
        logic [63:0] mn;
        logic [63:0] m1;
        int          k;
        mn = 64'h8000_0000_0000_0000;
        m1 = mdu_pkg::ALL_ONES;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b0;
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero divisor, overflow, extremes, ties, most negative
        add_req(mdu_pkg::ACT_UNSIGNED, 64'd100, 64'd3, 64'd7);
        add_req(mdu_pkg::ACT_UNSIGNED, 64'd5, 64'd5, 64'd0);
        add_req(mdu_pkg::ACT_SIGNED, 64'd5, 64'd5, 64'd0);
        add_req(mdu_pkg::ACT_UNSIGNED, m1, m1, m1);
        add_req(mdu_pkg::ACT_UNSIGNED, m1, 64'hFFFF_FFFF, 64'h1_0000_0000);
        add_req(mdu_pkg::ACT_UNSIGNED, m1, 64'd1, 64'd1);
        add_req(mdu_pkg::ACT_UNSIGNED, 64'hFFFF_FFFE_FFFF_FFFF, 64'hFFFF_FFFF,
                64'hFFFF_FFFF);
        add_req(mdu_pkg::ACT_UNSIGNED, 64'd0, m1, 64'hFFFF_FFFF);
        add_req(mdu_pkg::ACT_SIGNED, 64'd7, 64'd1, 64'd2);
        add_req(mdu_pkg::ACT_SIGNED, -64'd7, 64'd1, 64'd2);
        add_req(mdu_pkg::ACT_SIGNED, 64'd5, 64'd1, -64'd2);
        add_req(mdu_pkg::ACT_SIGNED, 64'd1, 64'd1, 64'd3);
        add_req(mdu_pkg::ACT_SIGNED, 64'd2, 64'd1, 64'd3);
        add_req(mdu_pkg::ACT_SIGNED, mn, 64'd1, 64'd1);
        add_req(mdu_pkg::ACT_SIGNED, mn, m1, 64'd1);
        add_req(mdu_pkg::ACT_SIGNED, mn, mn, mn);
        add_req(mdu_pkg::ACT_SIGNED, mn, 64'd2, 64'd2);
        add_req(mdu_pkg::ACT_SIGNED, m1, m1, m1);
        add_req(mdu_pkg::ACT_SIGNED, m1, 64'd1, 64'd1);
        add_req(mdu_pkg::ACT_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, mn);
        add_req(mdu_pkg::ACT_SIGNED, m1 >> 1, 64'd3, 64'd2);
        add_req(mdu_pkg::ACT_SIGNED, m1, 64'd1, 64'd2);
        add_req(mdu_pkg::ACT_SIGNED, 64'hFFFF_FFFF_FFFF_FFFF >> 0, 64'd0, 64'd1);
        add_req(mdu_pkg::ACT_SIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, mn);

        // let the directed set drain before random traffic
        wait (pending_reqs.size() == 0);
        hold_sender = 1'b1;
        wait (!s_axis_tvalid && expected_results.size() == 0);
        hold_sender = 1'b0;

        for (k = 0; k < N_RANDOM; k++) begin
            logic [63:0] a;
            logic [63:0] b;
            logic [63:0] c;
            logic        act;
            act = $urandom_range(0, 1);
            a = rand64();
            b = rand64();
            c = rand64();
            // mostly pick large unsigned divisors or small signed multipliers so a quotient exists
            if ($urandom_range(0, 3) != 0) begin
                if (act == mdu_pkg::ACT_UNSIGNED)
                    c[31:0] = c[31:0] | (32'h1 << $urandom_range(20, 31));
                else if ($urandom_range(0, 1) == 0)
                    b = {{32{b[31]}}, b[31:0]};
            end
            add_req(act, a, b, c);
            if (k == N_RANDOM / 2) begin
                wait (pending_reqs.size() == 0);
                hold_sender = 1'b1;
                wait (!s_axis_tvalid && expected_results.size() == 0);
                hold_sender = 1'b0;
            end
        end
        wait (pending_reqs.size() == 0 && !s_axis_tvalid);
        stim_done = 1'b1;
        wait (expected_results.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("checked %0d results: %0d signed requests, %0d overflow results",
                 n_results, n_signed, n_overflows);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
